// File: hdl/swr_pkg.sv
// ----------------------------------------------------------------------------
// swr_pkg
// shared constants, codes and types of the stack with roll block
// ----------------------------------------------------------------------------
`default_nettype none

package swr_pkg;

  localparam int unsigned STACK_DEPTH = 1024;
  localparam int unsigned ADDR_W      = $clog2(STACK_DEPTH);
  localparam int unsigned CNT_W       = ADDR_W + 1;
  localparam int unsigned DATA_W      = 32;

  typedef enum logic [1:0] {
    MODE_PUSH  = 2'd0,
    MODE_POP   = 2'd1,
    MODE_ROLL  = 2'd2,
    MODE_CLEAR = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    FAULT_NONE  = 2'd0,
    FAULT_EMPTY = 2'd1,
    FAULT_FULL  = 2'd2
  } fault_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POP,
    ST_DIV,
    ST_COPY,
    ST_GAP,
    ST_ROT,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic [1:0]        fault;
    logic              is_empty;
    logic [CNT_W-1:0]  stack_size;
    logic [DATA_W-1:0] popped_value;
  } result_t;

  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] dividend;
    logic [CNT_W-1:0]  divisor;
  } mod_req_t;

  typedef struct packed {
    logic             done;
    logic [CNT_W-1:0] remainder;
  } mod_rsp_t;

endpackage

`default_nettype wire

// File: hdl/swr_ram.sv
// ----------------------------------------------------------------------------
// swr_ram
// simple dual-port synchronous ram, one write and one registered read
// ----------------------------------------------------------------------------
`default_nettype none

module swr_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// File: hdl/swr_mod.sv
// ----------------------------------------------------------------------------
// swr_mod
// bit-serial restoring remainder unit, one dividend bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module swr_mod (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire swr_pkg::mod_req_t req_i,
  output swr_pkg::mod_rsp_t      rsp_o
);

  localparam int unsigned StepW = $clog2(swr_pkg::DATA_W);

  logic                       busy_q, busy_d;
  logic                       done_q, done_d;
  logic [StepW-1:0]           step_q, step_d;
  logic [swr_pkg::DATA_W-1:0] dvd_q, dvd_d;
  logic [swr_pkg::CNT_W-1:0]  dsr_q, dsr_d;
  logic [swr_pkg::CNT_W-1:0]  rem_q, rem_d;
  logic [swr_pkg::CNT_W:0]    trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    dvd_d  = dvd_q;
    dsr_d  = dsr_q;
    rem_d  = rem_q;
    trial  = {rem_q, dvd_q[swr_pkg::DATA_W-1]};
    if (req_i.start) begin
      busy_d = 1'b1;
      step_d = '0;
      dvd_d  = req_i.dividend;
      dsr_d  = req_i.divisor;
      rem_d  = '0;
    end else if (busy_q) begin
      dvd_d = {dvd_q[swr_pkg::DATA_W-2:0], 1'b0};
      if (trial >= {1'b0, dsr_q}) begin
        rem_d = swr_pkg::CNT_W'(trial - {1'b0, dsr_q});
      end else begin
        rem_d = trial[swr_pkg::CNT_W-1:0];
      end
      step_d = step_q + StepW'(1);
      if (step_q == StepW'(swr_pkg::DATA_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
    rem_q <= rem_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.remainder = rem_q;

endmodule

`default_nettype wire

// File: hdl/stack_with_roll.sv
// ----------------------------------------------------------------------------
// stack_with_roll
// bounded lifo stack of signed 32-bit words with push, pop, roll and clear
//
// one transaction on the s_axis side carries one operation, selected by
// tuser; each operation returns exactly one result transaction on m_axis
// holding the popped word, the size after the operation, an empty flag and
// a fault code. operations run one at a time; a new transaction is taken
// only while the output register is empty or is being read in that cycle.
// push, clear, pop from empty and a roll that changes nothing (depth or
// stack size of one or less) give their result in the cycle after
// acceptance; a pop from a non-empty stack also passes through ST_POP,
// because of the registered read of the stack ram. a roll that moves
// entries runs the serial remainder unit, copies the d-entry window into a
// buffer ram and writes it back rotated; a roll whose count is a multiple
// of d ends after the remainder.
// reset empties the stack at once; ram contents are not cleared.
// while m_axis_tready_i is low the result holds and no new transaction is
// taken until that result has been accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module stack_with_roll (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [95:0] s_axis_tdata_i,  // push_value, roll_depth, roll_count
  input  wire logic [1:0]  s_axis_tuser_i,  // mode
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [47:0]      m_axis_tdata_o   // popped_value, stack_size, is_empty, fault
);

  localparam int unsigned AW = swr_pkg::ADDR_W;
  localparam int unsigned CW = swr_pkg::CNT_W;
  localparam int unsigned DW = swr_pkg::DATA_W;

  swr_pkg::state_e  state_q, state_d;
  swr_pkg::result_t res_q, res_d;
  swr_pkg::mod_req_t mod_req;
  swr_pkg::mod_rsp_t mod_rsp;

  logic          out_valid_q, out_valid_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] depth_q, depth_d;
  logic          neg_q, neg_d;
  logic [AW-1:0] rm_q, rm_d;
  logic [AW-1:0] k_q, k_d;
  logic [AW-1:0] j_q, j_d;
  logic          bpend_q, bpend_d;
  logic [AW-1:0] bidx_q, bidx_d;
  logic          spend_q, spend_d;
  logic [AW-1:0] sidx_q, sidx_d;

  logic          accept;
  logic          load;
  logic [DW-1:0] load_pop;
  logic [1:0]    load_fault;

  logic          st_we;
  logic [AW-1:0] st_waddr, st_raddr;
  logic [DW-1:0] st_wdata, st_rdata;
  logic [AW-1:0] buf_raddr;
  logic [DW-1:0] buf_rdata;

  swr_pkg::mode_e       mode;
  logic signed [DW-1:0] push_value, roll_depth, roll_count;
  logic [CW-1:0]        count_dec;
  logic [AW-1:0]        top;
  logic [CW-1:0]        clamp;
  logic                 roll_nop;
  logic [CW-1:0]        rm_full;
  logic [AW-1:0]        last_k;

  assign mode       = swr_pkg::mode_e'(s_axis_tuser_i);
  assign push_value = s_axis_tdata_i[31:0];
  assign roll_depth = s_axis_tdata_i[63:32];
  assign roll_count = s_axis_tdata_i[95:64];

  assign s_axis_tready_o = (state_q == swr_pkg::ST_IDLE) && (!out_valid_q || m_axis_tready_i);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  assign count_dec = count_q - CW'(1);
  assign top       = count_dec[AW-1:0];
  assign last_k    = AW'(depth_q - CW'(1));

  assign clamp    = (roll_depth > $signed({{(DW-CW){1'b0}}, count_q})) ? count_q
                                                                       : roll_depth[CW-1:0];
  assign roll_nop = (roll_depth <= $signed(DW'(1))) || (count_q <= CW'(1));

  assign rm_full = (neg_q && (mod_rsp.remainder != '0)) ? depth_q - mod_rsp.remainder
                                                        : mod_rsp.remainder;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      swr_pkg::ST_IDLE: begin
        if (accept) begin
          case (mode)
            swr_pkg::MODE_POP: begin
              if (count_q != '0) begin
                state_d = swr_pkg::ST_POP;
              end
            end
            swr_pkg::MODE_ROLL: begin
              if (!roll_nop) begin
                state_d = swr_pkg::ST_DIV;
              end
            end
            default: state_d = swr_pkg::ST_IDLE;
          endcase
        end
      end
      swr_pkg::ST_POP: state_d = swr_pkg::ST_IDLE;
      swr_pkg::ST_DIV: begin
        if (mod_rsp.done) begin
          state_d = (rm_full == '0) ? swr_pkg::ST_IDLE : swr_pkg::ST_COPY;
        end
      end
      swr_pkg::ST_COPY: begin
        if (k_q == last_k) begin
          state_d = swr_pkg::ST_GAP;
        end
      end
      swr_pkg::ST_GAP: state_d = swr_pkg::ST_ROT;
      swr_pkg::ST_ROT: begin
        if (k_q == last_k) begin
          state_d = swr_pkg::ST_FIN;
        end
      end
      swr_pkg::ST_FIN: state_d = swr_pkg::ST_IDLE;
      default: state_d = swr_pkg::ST_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    count_d    = count_q;
    depth_d    = depth_q;
    neg_d      = neg_q;
    rm_d       = rm_q;
    k_d        = k_q;
    j_d        = j_q;
    bpend_d    = 1'b0;
    bidx_d     = bidx_q;
    spend_d    = 1'b0;
    sidx_d     = sidx_q;
    load       = 1'b0;
    load_pop   = '0;
    load_fault = swr_pkg::FAULT_NONE;
    st_we      = spend_q;
    st_waddr   = sidx_q;
    st_wdata   = buf_rdata;
    st_raddr   = AW'(top - k_q);
    buf_raddr  = j_q;
    mod_req.start    = 1'b0;
    mod_req.dividend = roll_count[DW-1] ? DW'(-roll_count) : DW'(roll_count);
    mod_req.divisor  = clamp;

    case (state_q)
      swr_pkg::ST_IDLE: begin
        st_raddr = top;
        if (accept) begin
          case (mode)
            swr_pkg::MODE_PUSH: begin
              load = 1'b1;
              if (count_q == CW'(swr_pkg::STACK_DEPTH)) begin
                load_fault = swr_pkg::FAULT_FULL;
              end else begin
                st_we    = 1'b1;
                st_waddr = count_q[AW-1:0];
                st_wdata = push_value;
                count_d  = count_q + CW'(1);
              end
            end
            swr_pkg::MODE_POP: begin
              if (count_q == '0) begin
                load       = 1'b1;
                load_fault = swr_pkg::FAULT_EMPTY;
              end else begin
                count_d = count_dec;
              end
            end
            swr_pkg::MODE_ROLL: begin
              if (roll_nop) begin
                load = 1'b1;
              end else begin
                mod_req.start = 1'b1;
                depth_d       = clamp;
                neg_d         = roll_count[DW-1];
              end
            end
            swr_pkg::MODE_CLEAR: begin
              load    = 1'b1;
              count_d = '0;
            end
            default: load = 1'b1;
          endcase
        end
      end
      swr_pkg::ST_POP: begin
        load     = 1'b1;
        load_pop = st_rdata;
      end
      swr_pkg::ST_DIV: begin
        if (mod_rsp.done) begin
          rm_d = rm_full[AW-1:0];
          k_d  = '0;
          if (rm_full == '0) begin
            load = 1'b1;
          end
        end
      end
      swr_pkg::ST_COPY: begin
        bpend_d = 1'b1;
        bidx_d  = k_q;
        k_d     = k_q + AW'(1);
      end
      swr_pkg::ST_GAP: begin
        k_d = '0;
        j_d = rm_q;
      end
      swr_pkg::ST_ROT: begin
        spend_d = 1'b1;
        sidx_d  = AW'(top - k_q);
        k_d     = k_q + AW'(1);
        j_d     = (j_q == last_k) ? '0 : j_q + AW'(1);
      end
      swr_pkg::ST_FIN: load = 1'b1;
      default: load = 1'b0;
    endcase

    res_d = res_q;
    if (load) begin
      res_d.popped_value = load_pop;
      res_d.stack_size   = count_d;
      res_d.is_empty     = (count_d == '0);
      res_d.fault        = load_fault;
    end
    if (load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= swr_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      count_q     <= '0;
      bpend_q     <= 1'b0;
      spend_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      count_q     <= count_d;
      bpend_q     <= bpend_d;
      spend_q     <= spend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q   <= res_d;
    depth_q <= depth_d;
    neg_q   <= neg_d;
    rm_q    <= rm_d;
    k_q     <= k_d;
    j_q     <= j_d;
    bidx_q  <= bidx_d;
    sidx_q  <= sidx_d;
  end

  swr_ram #(
    .DEPTH(swr_pkg::STACK_DEPTH),
    .WIDTH(DW)
  ) u_stack_ram (
    .clk_i  (clk_i),
    .we_i   (st_we),
    .waddr_i(st_waddr),
    .wdata_i(st_wdata),
    .raddr_i(st_raddr),
    .rdata_o(st_rdata)
  );

  swr_ram #(
    .DEPTH(swr_pkg::STACK_DEPTH),
    .WIDTH(DW)
  ) u_window_ram (
    .clk_i  (clk_i),
    .we_i   (bpend_q),
    .waddr_i(bidx_q),
    .wdata_i(st_rdata),
    .raddr_i(buf_raddr),
    .rdata_o(buf_rdata)
  );

  swr_mod u_mod (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (mod_req),
    .rsp_o (mod_rsp)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {2'b00, res_q};

endmodule

`default_nettype wire
